// ----- src/bba_pkg.sv -----
// Shared constants, types and helpers for the bitmap block allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bba_pkg;

	localparam int MAP_BYTES = 512;
	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int BLK_W     = AW + 3;
	localparam int INDEX_W   = 12;
	localparam int COUNT_W   = 13;
	localparam int TOTAL     = MAP_BYTES * 8;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	localparam logic [COUNT_W-1:0] FREE_INIT =
		COUNT_W'((TOTAL > COUNT_MAX) ? COUNT_MAX : TOTAL);
	localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);

	localparam logic [7:0] BIT_TOP   = 8'b1000_0000;
	localparam logic [7:0] BYTE_FULL = 8'b1111_1111;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [7:0]    wr_data;
	} map_req_t;

	typedef struct packed {
		logic [7:0] rd_data;
		logic       full;
		logic [2:0] zero_pos;
	} map_rsp_t;

	typedef struct packed {
		logic [INDEX_W-1:0] granted_index;
		logic               ok;
		logic [COUNT_W-1:0] free_left;
	} result_t;

	typedef struct packed {
		logic               clearing;
		logic [COUNT_W-1:0] free_cnt;
	} seq_stat_t;

	// position of the first clear bit, MSB first (0 = bit 7)
	function automatic logic [2:0] first_clear(input logic [7:0] b);
		logic [2:0] pos;
		logic       found;
		pos   = '0;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!found && !b[7-i]) begin
				pos   = 3'(i);
				found = 1'b1;
			end
		end
		return pos;
	endfunction

endpackage

// ----- src/bba_req_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
// Depends on bba_pkg.
`timescale 1ns / 1ps

interface bba_req_if;
	import bba_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [INDEX_W-1:0] entry_index;

	modport source (output valid, kind, entry_index, input ready);
	modport sink   (input valid, kind, entry_index, output ready);
endinterface

// ----- src/bba_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
// Depends on bba_pkg.
`timescale 1ns / 1ps

interface bba_rsp_if;
	import bba_pkg::*;

	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] granted_index;
	logic               ok;
	logic [COUNT_W-1:0] free_left;

	modport source (output valid, granted_index, ok, free_left, input ready);
	modport sink   (input valid, granted_index, ok, free_left, output ready);
endinterface

// ----- src/bitmap_block_allocator_top.sv -----
// Top level of the first-fit bitmap block allocator: sequencer, bitmap
// store and response register. Depends on bba_pkg, bba_req_if, bba_rsp_if.
`timescale 1ns / 1ps

//  channel | dir | word fields                          | handshake
//  req     | in  | kind, entry_index                    | valid/ready
//  rsp     | out | granted_index, ok, free_left         | valid/ready
//
//  Allocate: the scan reads bytes from 0 up to the first byte that is not
//  full, or up to the last byte; the one-byte-per-cycle read port of the
//  bitmap store paces the scan.
//  Free: read, modify-write, result. Allocate on a zero counter, or free
//  of an out-of-range index, skips to the result with ok low.
//  After reset a clearing pass writes zero to all MAP_BYTES bytes, one per
//  cycle; req.ready stays low until it ends.
//  One request in flight; a finished word waits in the rsp register while
//  the next request is accepted. A stalled rsp holds the sequencer in its
//  done step only.
module bitmap_block_allocator_top (
	input  logic     clk,
	input  logic     arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);
	import bba_pkg::*;

	map_req_t  map_req;
	map_rsp_t  map_rsp;
	result_t   res;
	seq_stat_t stat;
	logic      res_load;
	logic      res_room;
	logic      rsp_vld_q;

	// room in the response register when empty or being drained this cycle
	assign res_room = !rsp_vld_q || rsp.ready;

	bba_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_kind  (req.kind),
		.in_index (req.entry_index),
		.map_req  (map_req),
		.map_rsp  (map_rsp),
		.res_room (res_room),
		.res_load (res_load),
		.res      (res),
		.stat     (stat)
	);

	bba_map_store u_store (
		.clk (clk),
		.req (map_req),
		.rsp (map_rsp)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp.granted_index <= res.granted_index;
			rsp.ok            <= res.ok;
			rsp.free_left     <= res.free_left;
		end
	end

	assign rsp.valid = rsp_vld_q;

	// no requests taken while the bitmap is being cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !req.ready)
		else $error("request port ready during clearing pass");

	// the counter only moves at a scan hit or a free write, never right
	// after accept
	a_cnt_hold_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> $stable(stat.free_cnt))
		else $error("free counter changed right after accept");

	// a new result never overwrites an unread one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!rsp.valid || rsp.ready))
		else $error("response register overwritten while full");
endmodule

// ----- src/bba_map_store.sv -----
// Bitmap byte store (one write, one registered read port) and the byte
// tester that flags full bytes and finds the first clear bit. Uses bba_pkg.
`timescale 1ns / 1ps

module bba_map_store (
	input  logic              clk,
	input  bba_pkg::map_req_t req,
	output bba_pkg::map_rsp_t rsp
);
	import bba_pkg::*;

	logic [7:0] mem [MAP_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_comb begin
		rsp.rd_data  = rd_data_q;
		rsp.full     = (rd_data_q == BYTE_FULL);
		rsp.zero_pos = first_clear(rd_data_q);
	end
endmodule

// ----- src/bba_seq.sv -----
// Sequencer: clearing pass, byte scan for allocate, read-modify-write for
// free, and the free counter. Drives bba_map_store. Uses bba_pkg.
`timescale 1ns / 1ps

module bba_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_kind,
	input  logic [bba_pkg::INDEX_W-1:0] in_index,
	output bba_pkg::map_req_t  map_req,
	input  bba_pkg::map_rsp_t  map_rsp,
	input  logic               res_room,
	output logic               res_load,
	output bba_pkg::result_t   res,
	output bba_pkg::seq_stat_t stat
);
	import bba_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_SCAN    = 6'b000100,
		S_FREE_RD = 6'b001000,
		S_FREE_WR = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      daddr_q;
	logic               dvld_q;
	logic [INDEX_W-1:0] idx_q;
	logic [INDEX_W-1:0] gnt_q;
	logic               ok_q;
	logic [COUNT_W-1:0] free_q;

	logic [AW-1:0]      addr_next;
	logic [AW-1:0]      free_addr;
	logic               in_range;
	logic               accept;

	assign addr_next = (addr_q == LAST_BYTE) ? '0 : addr_q + 1'b1;
	assign free_addr = AW'(idx_q[INDEX_W-1:3]);
	assign in_range  = (32'(in_index[INDEX_W-1:3]) < 32'(MAP_BYTES));
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_load  = (state_q == S_DONE) && res_room;

	assign res.granted_index = gnt_q;
	assign res.ok            = ok_q;
	assign res.free_left     = free_q;
	assign stat.clearing     = (state_q == S_CLEAR);
	assign stat.free_cnt     = free_q;

	always_comb begin
		map_req         = '0;
		map_req.rd_addr = addr_q;
		map_req.wr_addr = daddr_q;
		map_req.wr_data = map_rsp.rd_data | (BIT_TOP >> map_rsp.zero_pos);
		unique case (state_q)
			S_CLEAR: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = addr_q;
				map_req.wr_data = '0;
			end
			S_SCAN: begin
				map_req.rd_en = 1'b1;
				map_req.wr_en = dvld_q && !map_rsp.full;
			end
			S_FREE_RD: begin
				map_req.rd_en   = 1'b1;
				map_req.rd_addr = free_addr;
			end
			S_FREE_WR: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = free_addr;
				map_req.wr_data = map_rsp.rd_data ^ (BIT_TOP >> idx_q[2:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			dvld_q  <= 1'b0;
			free_q  <= FREE_INIT;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_next;
					if (addr_q == LAST_BYTE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						dvld_q <= 1'b0;
						if (in_kind == KIND_ALLOC) begin
							state_q <= (free_q == '0) ? S_DONE : S_SCAN;
						end else begin
							state_q <= in_range ? S_FREE_RD : S_DONE;
						end
					end
				end
				S_SCAN: begin
					addr_q  <= addr_next;
					daddr_q <= addr_q;
					dvld_q  <= 1'b1;
					if (dvld_q) begin
						if (!map_rsp.full) begin
							free_q  <= free_q - 1'b1;
							state_q <= S_DONE;
						end else if (daddr_q == LAST_BYTE) begin
							state_q <= S_DONE;
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					free_q  <= free_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_room) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and result fields: no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= in_index;
			ok_q  <= 1'b0;
			gnt_q <= '0;
		end else if ((state_q == S_SCAN) && dvld_q && !map_rsp.full) begin
			ok_q  <= 1'b1;
			gnt_q <= INDEX_W'({daddr_q, map_rsp.zero_pos});
		end else if (state_q == S_FREE_WR) begin
			ok_q  <= 1'b1;
		end
	end
endmodule
